// File: hdl/video_port_and_scanline_timer_macros.svh
// Assertion shorthands shared by the video port RTL.
// Each expects clk and rst_n in scope; checks are off while in reset.
`ifndef VIDEO_PORT_AND_SCANLINE_TIMER_MACROS_SVH
`define VIDEO_PORT_AND_SCANLINE_TIMER_MACROS_SVH

// property must hold at every clock edge out of reset
`define VPST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true out of reset
`define VPST_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: hdl/vpst_pkg.sv
package vpst_pkg;

  // video memory geometry
  localparam int VRAM_DEPTH = 16384;
  localparam int VRAM_AW    = 14;

  // frame lengths
  localparam logic [9:0] LINES_PAL  = 10'd313;
  localparam logic [9:0] LINES_NTSC = 10'd262;

  // host port actions
  typedef enum logic [2:0] {
    ACT_CTRL_WR = 3'd0,
    ACT_DATA_WR = 3'd1,
    ACT_DATA_RD = 3'd2,
    ACT_STAT_RD = 3'd3,
    ACT_TICK    = 3'd4
  } action_t;

  // access codes set by the second control byte
  typedef enum logic [1:0] {
    CODE_VRAM_RD = 2'd0,
    CODE_VRAM_WR = 2'd1,
    CODE_REG_WR  = 2'd2,
    CODE_PAL_WR  = 2'd3
  } access_code_t;

  // mode register indexes that affect behaviour
  localparam logic [3:0] REG_MODE0    = 4'd0;
  localparam logic [3:0] REG_MODE1    = 4'd1;
  localparam logic [3:0] REG_LINE_CNT = 4'd10;

  // result word
  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] vertical_count;
    logic       interrupt_request;
  } out_word_t;

  // scanline to vertical counter mapping for one standard and height
  typedef struct packed {
    logic [7:0] active;
    logic [7:0] start0;
    logic [7:0] start1;
    logic [7:0] start2;
    logic [8:0] size0;
    logic [8:0] size1;
    logic [8:0] size2;
  } line_map_t;

  // height class from the mode bits: {supported, class}
  // class 0: 192 lines, 1: 224 lines, 2: 240 lines
  function automatic logic [2:0] mode_class(input logic [7:0] r0, input logic [7:0] r1);
    logic [3:0] m;
    logic [2:0] res;
    m = {r0[2], r1[3], r0[1], r1[4]};
    case (m) inside
      4'd8, 4'd10, 4'd12, 4'd15: res = 3'b100;
      4'd11:                     res = 3'b101;
      4'd14:                     res = 3'b110;
      default:                   res = 3'b000;
    endcase
    return res;
  endfunction

  function automatic line_map_t line_map(input logic std, input logic [1:0] cls);
    line_map_t mp;
    case ({std, cls})
      3'b000:  mp = '{8'd192, 8'h00, 8'hba, 8'h00, 9'h0f3, 9'h046, 9'h000};
      3'b001:  mp = '{8'd224, 8'h00, 8'h00, 8'hca, 9'h100, 9'h003, 9'h036};
      3'b010:  mp = '{8'd240, 8'h00, 8'h00, 8'hd2, 9'h100, 9'h00b, 9'h02e};
      3'b100:  mp = '{8'd192, 8'h00, 8'hd5, 8'h00, 9'h0db, 9'h02b, 9'h000};
      3'b101:  mp = '{8'd224, 8'h00, 8'he5, 8'h00, 9'h0eb, 9'h01b, 9'h000};
      3'b110:  mp = '{8'd240, 8'h00, 8'h00, 8'h00, 9'h100, 9'h007, 9'h000};
      default: mp = '0;
    endcase
    return mp;
  endfunction

endpackage

// File: hdl/vpst_in_if.sv
// Host access word channel
interface vpst_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] bus_data;

  modport source (output valid, output action, output bus_data, input ready);
  modport sink   (input valid, input action, input bus_data, output ready);
endinterface

// File: hdl/vpst_out_if.sv
// Result word channel
interface vpst_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [7:0] vertical_count;
  logic       interrupt_request;

  modport source (output valid, output read_data, output vertical_count,
                  output interrupt_request, input ready);
  modport sink   (input valid, input read_data, input vertical_count,
                  input interrupt_request, output ready);
endinterface

// File: hdl/video_port_and_scanline_timer.sv
// Video display processor host port and scanline timer.
// in_port carries one host access per word: control write, data write,
// data read, status read or scanline tick, with the bus byte. Every accepted
// word gives exactly one result word on out_port: the read byte (data read
// buffer or status), the vertical counter and the interrupt request.
// cfg_wr_en/cfg_wr_data write the video standard (0 PAL, 1 NTSC); the user
// must do so only while idle: the block does not enforce it. Throughput: one
// word per cycle while in_port.ready is high. Video memory is a synchronous
// RAM with one write and one read port; a prefetched byte arrives in the
// cycle after the read and is forwarded to a data read that follows at once.
// Reset: the control state clears, then a clearing pass zeroes video memory
// one byte a cycle; in_port.ready stays low until it ends. Stall: an output
// register plus one skid register hold results, so one more word is taken
// while the receiver stalls; then in_port.ready drops. Palette writes have
// no read path towards the results and are dropped.
`include "video_port_and_scanline_timer_macros.svh"
module video_port_and_scanline_timer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  vpst_in_if.sink           in_port,
  vpst_out_if.source        out_port
);

  // state registers
  logic                             std_r;
  logic [vpst_pkg::VRAM_AW-1:0]     addr_r, addr_nxt;
  logic [1:0]                       code_r, code_nxt;
  logic [7:0]                       prefetch_r, prefetch_nxt;
  logic                             pf_load_r, pf_load_nxt;
  logic                             pending_r, pending_nxt;
  logic                             frame_r, frame_nxt;
  logic                             lflag_r, lflag_nxt;
  logic [7:0]                       ldc_r, ldc_nxt;
  logic [8:0]                       line_r, line_nxt;
  logic [7:0]                       vc_r, vc_nxt;
  logic [7:0]                       mode0_r, mode0_nxt;
  logic [7:0]                       mode1_r, mode1_nxt;
  logic [7:0]                       mode10_r, mode10_nxt;
  logic                             clr_r;
  logic [vpst_pkg::VRAM_AW-1:0]     clr_addr_r;

  // output register and skid stage
  logic                             out_valid_r, out_valid_nxt;
  logic                             skid_valid_r, skid_valid_nxt;
  vpst_pkg::out_word_t              out_word_r, out_word_nxt;
  vpst_pkg::out_word_t              skid_word_r, skid_word_nxt;
  vpst_pkg::out_word_t              res_word;

  logic                             in_fire, out_fire;
  logic [7:0]                       pf_cur;
  logic [7:0]                       rd_byte;
  logic                             host_we, rd_issue;
  logic [vpst_pkg::VRAM_AW-1:0]     ram_raddr, ram_waddr, new_addr;
  logic                             ram_we;
  logic [7:0]                       ram_wdata, ram_rdata;

  // tick datapath
  logic [2:0]                       tk_cls;
  vpst_pkg::line_map_t              tk_map;
  logic [9:0]                       tk_total, tk_inc;
  logic [8:0]                       tk_line, tk_l1, tk_l2;
  logic [7:0]                       tk_vc, tk_ldc;
  logic                             tk_frame, tk_lflag;

  assign in_port.ready = !skid_valid_r && !clr_r;
  assign in_fire       = in_port.valid && in_port.ready;
  assign out_fire      = out_valid_r && out_port.ready;

  // prefetched byte, forwarded while the RAM read is in flight
  assign pf_cur = pf_load_r ? ram_rdata : prefetch_r;

  // video memory with clearing pass after reset
  assign ram_we    = clr_r || host_we;
  assign ram_waddr = clr_r ? clr_addr_r : addr_r;
  assign ram_wdata = clr_r ? 8'h00 : in_port.bus_data;

  vpst_ram #(
    .WIDTH (8),
    .DEPTH (vpst_pkg::VRAM_DEPTH)
  ) u_vram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // scanline tick: frame flag, line counter, line advance and counter mapping
  always_comb begin
    tk_cls   = vpst_pkg::mode_class(mode0_r, mode1_r);
    tk_map   = vpst_pkg::line_map(std_r, tk_cls[1:0]);
    tk_total = std_r ? vpst_pkg::LINES_NTSC : vpst_pkg::LINES_PAL;
    tk_frame = frame_r || (line_r == ({1'b0, tk_map.active} + 9'd1));
    tk_lflag = lflag_r;
    if (line_r <= {1'b0, tk_map.active}) begin
      tk_ldc = ldc_r - 8'd1;
      if (tk_ldc == 8'hff) begin
        tk_ldc   = mode10_r;
        tk_lflag = 1'b1;
      end
    end else begin
      tk_ldc = mode10_r;
    end
    // a line left over from the other standard is reduced by one subtract
    tk_inc = {1'b0, line_r} + 10'd1;
    if (tk_inc >= tk_total) begin
      tk_inc = tk_inc - tk_total;
    end
    tk_line = tk_inc[8:0];
    // walk the three counter ranges
    tk_l1 = tk_line - tk_map.size0;
    tk_l2 = tk_l1 - tk_map.size1;
    if (tk_line < tk_map.size0) begin
      tk_vc = tk_line[7:0] + tk_map.start0;
    end else if (tk_l1 < tk_map.size1) begin
      tk_vc = tk_l1[7:0] + tk_map.start1;
    end else if (tk_l2 < tk_map.size2) begin
      tk_vc = tk_l2[7:0] + tk_map.start2;
    end else begin
      tk_vc = vc_r;
    end
  end

  // host access decode
  always_comb begin
    addr_nxt     = addr_r;
    code_nxt     = code_r;
    prefetch_nxt = pf_cur;
    pending_nxt  = pending_r;
    frame_nxt    = frame_r;
    lflag_nxt    = lflag_r;
    ldc_nxt      = ldc_r;
    line_nxt     = line_r;
    vc_nxt       = vc_r;
    mode0_nxt    = mode0_r;
    mode1_nxt    = mode1_r;
    mode10_nxt   = mode10_r;
    rd_byte      = 8'h00;
    host_we      = 1'b0;
    rd_issue     = 1'b0;
    ram_raddr    = addr_r;
    new_addr     = {in_port.bus_data[5:0], addr_r[7:0]};
    if (in_fire) begin
      case (in_port.action)
        vpst_pkg::ACT_CTRL_WR: begin
          if (!pending_r) begin
            pending_nxt = 1'b1;
            addr_nxt    = {addr_r[13:8], in_port.bus_data};
          end else begin
            pending_nxt = 1'b0;
            code_nxt    = in_port.bus_data[7:6];
            addr_nxt    = new_addr;
            if (in_port.bus_data[7:6] == vpst_pkg::CODE_VRAM_RD) begin
              rd_issue  = 1'b1;
              ram_raddr = new_addr;
              addr_nxt  = new_addr + 14'd1;
            end else if (in_port.bus_data[7:6] == vpst_pkg::CODE_REG_WR) begin
              case (in_port.bus_data[3:0])
                vpst_pkg::REG_MODE0:    mode0_nxt  = addr_r[7:0];
                vpst_pkg::REG_MODE1:    mode1_nxt  = addr_r[7:0];
                vpst_pkg::REG_LINE_CNT: mode10_nxt = addr_r[7:0];
                default: ;
              endcase
            end
          end
        end
        vpst_pkg::ACT_DATA_WR: begin
          pending_nxt = 1'b0;
          host_we     = (code_r != vpst_pkg::CODE_PAL_WR);
          addr_nxt    = addr_r + 14'd1;
        end
        vpst_pkg::ACT_DATA_RD: begin
          rd_byte     = pf_cur;
          pending_nxt = 1'b0;
          rd_issue    = 1'b1;
          addr_nxt    = addr_r + 14'd1;
        end
        vpst_pkg::ACT_STAT_RD: begin
          rd_byte     = {frame_r, 7'b0};
          pending_nxt = 1'b0;
          frame_nxt   = 1'b0;
          lflag_nxt   = 1'b0;
        end
        vpst_pkg::ACT_TICK: begin
          if (tk_cls[2]) begin
            frame_nxt = tk_frame;
            lflag_nxt = tk_lflag;
            ldc_nxt   = tk_ldc;
            line_nxt  = tk_line;
            vc_nxt    = tk_vc;
          end
        end
        default: ;
      endcase
    end
    pf_load_nxt = rd_issue;
    res_word.read_data         = rd_byte;
    res_word.vertical_count    = vc_nxt;
    res_word.interrupt_request = (mode1_nxt[5] && frame_nxt) || (mode0_nxt[4] && lflag_nxt);
  end

  // output register and skid stage
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_word_nxt   = out_word_r;
    skid_valid_nxt = skid_valid_r;
    skid_word_nxt  = skid_word_r;
    if (out_fire || !out_valid_r) begin
      if (skid_valid_r) begin
        out_word_nxt   = skid_word_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_word_nxt  = res_word;
        out_valid_nxt = in_fire;
      end
    end else if (in_fire) begin
      skid_word_nxt  = res_word;
      skid_valid_nxt = 1'b1;
    end
  end

  assign out_port.valid             = out_valid_r;
  assign out_port.read_data         = out_word_r.read_data;
  assign out_port.vertical_count    = out_word_r.vertical_count;
  assign out_port.interrupt_request = out_word_r.interrupt_request;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      std_r        <= 1'b0;
      addr_r       <= '0;
      code_r       <= '0;
      prefetch_r   <= '0;
      pf_load_r    <= 1'b0;
      pending_r    <= 1'b0;
      frame_r      <= 1'b0;
      lflag_r      <= 1'b0;
      ldc_r        <= '0;
      line_r       <= '0;
      vc_r         <= '0;
      mode0_r      <= '0;
      mode1_r      <= '0;
      mode10_r     <= '0;
      clr_r        <= 1'b1;
      clr_addr_r   <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        std_r <= cfg_wr_data;
      end
      addr_r       <= addr_nxt;
      code_r       <= code_nxt;
      prefetch_r   <= prefetch_nxt;
      pf_load_r    <= pf_load_nxt;
      pending_r    <= pending_nxt;
      frame_r      <= frame_nxt;
      lflag_r      <= lflag_nxt;
      ldc_r        <= ldc_nxt;
      line_r       <= line_nxt;
      vc_r         <= vc_nxt;
      mode0_r      <= mode0_nxt;
      mode1_r      <= mode1_nxt;
      mode10_r     <= mode10_nxt;
      if (clr_r) begin
        clr_addr_r <= clr_addr_r + 14'd1;
        clr_r      <= (clr_addr_r != '1);
      end
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_word_r  <= out_word_nxt;
    skid_word_r <= skid_word_nxt;
  end

  `VPST_NEVER(a_no_word_during_clear, in_fire && clr_r, "word accepted during memory clear")
  `VPST_NEVER(a_no_host_write_during_clear, host_we && clr_r, "host write during memory clear")
  `VPST_ASSERT(a_skid_implies_out, skid_valid_r |-> out_valid_r, "skid full with output empty")
  `VPST_ASSERT(a_pf_load_follows_read, pf_load_r |-> $past(rd_issue), "prefetch load without read")
  `VPST_ASSERT(a_word_gives_result, in_fire |=> out_valid_r, "accepted word left no result")

endmodule

// File: hdl/vpst_ram.sv
// Simple dual-port RAM, one write and one registered read port
module vpst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: test/vdp_port_checker.sv
`timescale 1ns / 1ps

// Watches the host and result channels, predicts each result word from the
// host accesses it sees, and compares results in order.
module vdp_port_checker
  import vpst_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_wr_en,
  input  logic cfg_wr_data,
  vpst_in_if   host_mon,
  vpst_out_if  res_mon,
  output int   mismatches,
  output int   results_due
);

  // shadow of the display processor state
  logic [7:0]   vram [VRAM_DEPTH];
  logic [7:0]   palette [32];
  logic [7:0]   mode_reg [11];
  logic [13:0]  acc_addr;
  access_code_t acc_code;
  logic [7:0]   read_buf;
  logic         half_latched;
  logic         frame_pend;
  logic         line_pend;
  logic [7:0]   line_cnt;
  logic [8:0]   line_no;
  logic [7:0]   vcount;
  logic         ntsc;

  out_word_t    pending_results [$];

  // line to vertical counter ranges, index standard * 3 + height class
  int line_active [6]   = '{192, 224, 240, 192, 224, 240};
  int line_start  [6][3] = '{'{0, 'hba, 0}, '{0, 0, 'hca}, '{0, 0, 'hd2},
                             '{0, 'hd5, 0}, '{0, 'he5, 0}, '{0, 0, 0}};
  int line_size   [6][3] = '{'{'hf3, 'h46, 0}, '{'h100, 'h03, 'h36},
                             '{'h100, 'h0b, 'h2e}, '{'hdb, 'h2b, 0},
                             '{'heb, 'h1b, 0}, '{'h100, 'h07, 0}};

  // apply one host access to the shadow state and return its result word
  function automatic out_word_t host_access(input logic [2:0] act,
                                            input logic [7:0] data);
    out_word_t  res;
    logic [3:0] mode;
    logic [3:0] reg_idx;
    int         cls;
    int         sel;
    int         line;
    int         total;
    bit         mapped;
    res = '0;
    case (act)
      ACT_CTRL_WR: begin
        if (!half_latched) begin
          half_latched = 1'b1;
          acc_addr[7:0] = data;
        end else begin
          half_latched = 1'b0;
          acc_addr[13:8] = data[5:0];
          acc_code = access_code_t'(data[7:6]);
          reg_idx = data[3:0];
          if (acc_code == CODE_VRAM_RD) begin
            read_buf = vram[acc_addr];
            acc_addr = acc_addr + 14'd1;
          end else if (acc_code == CODE_REG_WR && reg_idx <= REG_LINE_CNT) begin
            mode_reg[reg_idx] = acc_addr[7:0];
          end
        end
      end
      ACT_DATA_WR: begin
        half_latched = 1'b0;
        if (acc_code == CODE_PAL_WR) palette[acc_addr[4:0]] = data;
        else vram[acc_addr] = data;
        acc_addr = acc_addr + 14'd1;
      end
      ACT_DATA_RD: begin
        res.read_data = read_buf;
        half_latched = 1'b0;
        read_buf = vram[acc_addr];
        acc_addr = acc_addr + 14'd1;
      end
      ACT_STAT_RD: begin
        res.read_data = {frame_pend, 7'd0};
        half_latched = 1'b0;
        frame_pend = 1'b0;
        line_pend = 1'b0;
      end
      ACT_TICK: begin
        mode = {mode_reg[0][2], mode_reg[1][3], mode_reg[0][1], mode_reg[1][4]};
        case (mode)
          4'd8, 4'd10, 4'd12, 4'd15: cls = 0;
          4'd11:                     cls = 1;
          4'd14:                     cls = 2;
          default:                   cls = -1;
        endcase
        // unsupported modes leave the timer frozen
        if (cls >= 0) begin
          sel = (ntsc ? 3 : 0) + cls;
          total = ntsc ? int'(LINES_NTSC) : int'(LINES_PAL);
          line = int'(line_no);
          if (line == line_active[sel] + 1) frame_pend = 1'b1;
          if (line <= line_active[sel]) begin
            line_cnt = line_cnt - 8'd1;
            if (line_cnt == 8'hff) begin
              line_cnt = mode_reg[10];
              line_pend = 1'b1;
            end
          end else begin
            line_cnt = mode_reg[10];
          end
          // a line left over from the other standard folds back here
          line = (line + 1) % total;
          line_no = line[8:0];
          mapped = 1'b0;
          for (int r = 0; r < 3; r++) begin
            if (!mapped) begin
              if (line < line_size[sel][r]) begin
                vcount = 8'(line + line_start[sel][r]);
                mapped = 1'b1;
              end else begin
                line = line - line_size[sel][r];
              end
            end
          end
        end
      end
      default: ;
    endcase
    res.vertical_count = vcount;
    res.interrupt_request = (mode_reg[1][5] && frame_pend) || (mode_reg[0][4] && line_pend);
    return res;
  endfunction

  // reset, configuration, result comparison and prediction, all at the edge
  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      foreach (vram[i]) vram[i] = 8'd0;
      foreach (palette[i]) palette[i] = 8'd0;
      foreach (mode_reg[i]) mode_reg[i] = 8'd0;
      acc_addr = '0;
      acc_code = CODE_VRAM_RD;
      read_buf = '0;
      half_latched = 1'b0;
      frame_pend = 1'b0;
      line_pend = 1'b0;
      line_cnt = '0;
      line_no = '0;
      vcount = '0;
      ntsc = 1'b0;
      mismatches = 0;
      pending_results.delete();
    end else begin
      if (cfg_wr_en) ntsc = cfg_wr_data;
      if (res_mon.valid && res_mon.ready) begin
        if (pending_results.size() == 0) begin
          $error("result word with no expectation waiting");
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (res_mon.read_data !== want.read_data) begin
            $error("read_data: expected %02h, got %02h", want.read_data, res_mon.read_data);
            mismatches++;
          end
          if (res_mon.vertical_count !== want.vertical_count) begin
            $error("vertical_count: expected %02h, got %02h",
                   want.vertical_count, res_mon.vertical_count);
            mismatches++;
          end
          if (res_mon.interrupt_request !== want.interrupt_request) begin
            $error("interrupt_request: expected %0b, got %0b",
                   want.interrupt_request, res_mon.interrupt_request);
            mismatches++;
          end
        end
      end
      if (host_mon.valid && host_mon.ready)
        pending_results.push_back(host_access(host_mon.action, host_mon.bus_data));
    end
    results_due = pending_results.size();
  end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import vpst_pkg::*;

  // the memory clearing pass after reset is the longest quiet stretch
  localparam int STALL_LIMIT = 100000;
  localparam int PHASE_WORDS = 300;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic cfg_wr_data;
  int   mismatches;
  int   results_due;
  int   words_sent;
  int   burst_left;
  int   sink_run;
  int   sink_mode;
  int   quiet_cycles;

  vpst_in_if  in_ch ();
  vpst_out_if out_ch ();

  video_port_and_scanline_timer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_port     (in_ch),
    .out_port    (out_ch)
  );

  vdp_port_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .host_mon    (in_ch),
    .res_mon     (out_ch),
    .mismatches  (mismatches),
    .results_due (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side: stall pattern is redrawn at random after each run
  always @(negedge clk) begin
    if (sink_run == 0) begin
      sink_mode = $urandom_range(0, 2);
      sink_run = $urandom_range(20, 200);
    end
    sink_run--;
    case (sink_mode)
      0:       out_ch.ready = 1'b1;
      1:       out_ch.ready = ($urandom_range(0, 1) == 1);
      default: out_ch.ready = ($urandom_range(0, 3) == 0);
    endcase
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // one host word, sent in bursts with random gaps; called at a falling edge
  task automatic send(input logic [2:0] act, input logic [7:0] data);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 20);
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 10);
    end
    in_ch.valid = 1'b1;
    in_ch.action = act;
    in_ch.bus_data = data;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    words_sent++;
    @(negedge clk);
  endtask

  task automatic set_reg(input logic [3:0] idx, input logic [7:0] val);
    send(ACT_CTRL_WR, val);
    send(ACT_CTRL_WR, {CODE_REG_WR, 2'($urandom_range(0, 3)), idx});
  endtask

  task automatic set_addr(input logic [13:0] addr, input access_code_t code);
    send(ACT_CTRL_WR, addr[7:0]);
    send(ACT_CTRL_WR, {code, addr[13:8]});
  endtask

  // hold the sender until every outstanding result has come back
  task automatic drain();
    in_ch.valid = 1'b0;
    while (results_due != 0) @(negedge clk);
  endtask

  task automatic set_standard(input logic ntsc);
    drain();
    repeat (4) @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = ntsc;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // pick a supported display mode most of the time, irq enables at random
  task automatic set_display_mode();
    logic [3:0] mode;
    logic [7:0] r0;
    logic [7:0] r1;
    logic [3:0] good_modes [6];
    good_modes = '{4'd8, 4'd10, 4'd11, 4'd12, 4'd14, 4'd15};
    mode = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 15))
                                       : good_modes[$urandom_range(0, 5)];
    r0 = 8'($urandom);
    r1 = 8'($urandom);
    r0[1] = mode[1];
    r0[2] = mode[3];
    r1[4] = mode[0];
    r1[3] = mode[2];
    set_reg(REG_MODE0, r0);
    set_reg(REG_MODE1, r1);
  endtask

  // block start addresses: low memory, a page, just below the wrap, anywhere
  function automatic logic [13:0] pick_base();
    case ($urandom_range(0, 3))
      0:       return 14'h0000;
      1:       return 14'h0100;
      2:       return 14'h3ffa;
      default: return 14'($urandom);
    endcase
  endfunction

  initial begin
    int n;
    logic [13:0] base;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_CTRL_WR;
    in_ch.bus_data = 8'd0;
    words_sent = 0;
    burst_left = 0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    set_standard(1'b0);

    // directed: reset values, unknown actions, unsupported mode tick
    send(ACT_DATA_RD, 8'h00);
    send(ACT_STAT_RD, 8'hff);
    send(ACT_TICK, 8'h00);
    send(3'd5, 8'hff);
    send(3'd7, 8'h00);
    // 240-line mode with both interrupts enabled, short line count
    set_reg(REG_MODE0, 8'h16);
    set_reg(REG_MODE1, 8'h28);
    set_reg(REG_LINE_CNT, 8'h01);
    // register index beyond the last register
    send(ACT_CTRL_WR, 8'haa);
    send(ACT_CTRL_WR, {CODE_REG_WR, 2'b00, 4'hf});
    // lone first control byte, dropped by a data read
    send(ACT_CTRL_WR, 8'h3c);
    send(ACT_DATA_RD, 8'h00);
    // writes and prefetch across the top of video memory
    set_addr(14'h3fff, CODE_VRAM_WR);
    send(ACT_DATA_WR, 8'hff);
    send(ACT_DATA_WR, 8'h00);
    set_addr(14'h3fff, CODE_VRAM_RD);
    send(ACT_DATA_RD, 8'h00);
    set_addr(14'h001f, CODE_PAL_WR);
    send(ACT_DATA_WR, 8'h5a);
    send(ACT_TICK, 8'h00);
    send(ACT_TICK, 8'hff);
    send(ACT_STAT_RD, 8'h00);

    // random phases, alternating standards
    for (int ph = 0; ph < 6; ph++) begin
      set_standard(ph[0] ? 1'b0 : 1'b1);
      set_display_mode();
      set_reg(REG_LINE_CNT, 8'($urandom_range(0, 15)));
      n = words_sent + PHASE_WORDS;
      while (words_sent < n) begin
        case ($urandom_range(0, 99)) inside
          [0:39]: begin
            repeat ($urandom_range(1, 30)) send(ACT_TICK, 8'($urandom));
          end
          [40:49]: begin
            set_display_mode();
            if ($urandom_range(0, 1) == 0)
              set_reg(REG_LINE_CNT, ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                                 : 8'($urandom_range(0, 15)));
          end
          [50:64]: begin
            base = pick_base();
            set_addr(base, CODE_VRAM_WR);
            repeat ($urandom_range(1, 8)) send(ACT_DATA_WR, 8'($urandom));
          end
          [65:79]: begin
            base = pick_base();
            set_addr(base, CODE_VRAM_RD);
            repeat ($urandom_range(1, 8)) send(ACT_DATA_RD, 8'($urandom));
          end
          [80:84]: begin
            set_addr(14'($urandom), CODE_PAL_WR);
            repeat ($urandom_range(1, 4)) send(ACT_DATA_WR, 8'($urandom));
          end
          [85:92]: send(ACT_STAT_RD, 8'($urandom));
          [93:96]: send(3'($urandom_range(0, 7)), 8'($urandom));
          [97:98]: set_reg(4'($urandom_range(0, 15)), 8'($urandom));
          default: drain();
        endcase
      end
    end

    // wait for the last results, then watch for stray words
    drain();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && results_due == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
